[rtl/rffc_pkg.sv]
// shared types, constants and the crc-8 byte update for the fixed frame checker
package rffc_pkg;

    // defaults for the top level parameters
    localparam int ID_BYTES_DEF        = 4;
    localparam int MAX_FRAME_BYTES_DEF = 16;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int FLEN_W      = 5;
    localparam int NET_ID_W    = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int IN_TDATA_W  = 8;
    localparam int RES_W       = 3 + NET_ID_W + BYTE_W;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
    // width for length and position compares (covers every legal frame size)
    localparam int CMP_W       = 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ID       = 1'b1;

    // reset values
    localparam logic [FLEN_W-1:0]   FRAME_LENGTH_RST = 5'd6;
    localparam logic [NET_ID_W-1:0] OWN_ID_RST       = 32'd0;

    // crc-8, polynomial x^8 + x^2 + x + 1, msb first
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

    // byte request from the input register to the frame core
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_in_req;

    // core status back to the input register and the checks
    typedef struct packed {
        logic advance;
        logic frame_end;
    } t_core_status;

    // one frame verdict
    typedef struct packed {
        logic [BYTE_W-1:0]   message_byte;
        logic [NET_ID_W-1:0] frame_network_id;
        logic                universal_id_match;
        logic                own_id_match;
        logic                crc_good;
    } t_result;

    // one byte through the crc register, one bit per step
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/rx_fixed_frame_crc8_checker.sv]
// fixed-length frame checker: crc-8 verdict, network id and message byte per frame
// flow: a byte enters the input register on accept; the result of a closing byte
//   is loaded into the output register when that byte leaves the input register
// throughput: one byte per cycle, set by the single byte-wide crc update stage;
//   a full output register stalls the closing byte of the next frame and bytes behind it
// reset: synchronous active low, clears frame position, crc, id and valids, loads config
//   reset values
module rx_fixed_frame_crc8_checker #(
    parameter int ID_BYTES        = rffc_pkg::ID_BYTES_DEF,
    parameter int MAX_FRAME_BYTES = rffc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input byte stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [rffc_pkg::IN_TDATA_W-1:0]    i_s_tdata,   // [7:0] data_byte
    // frame results
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [0] crc_good, [1] own_id_match, [2] universal_id_match,
    // [34:3] frame_network_id, [42:35] message_byte, [47:43] zero
    output logic [rffc_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [rffc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [rffc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    logic [rffc_pkg::FLEN_W-1:0]    r_frame_length;
    logic [rffc_pkg::NET_ID_W-1:0]  r_own_network_id;

    rffc_pkg::t_in_req              w_req;
    rffc_pkg::t_core_status         w_status;
    rffc_pkg::t_result              w_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length   <= rffc_pkg::FRAME_LENGTH_RST;
            r_own_network_id <= rffc_pkg::OWN_ID_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rffc_pkg::REG_FRAME_LENGTH: begin
                    r_frame_length <= i_cfg_wdata[rffc_pkg::FLEN_W-1:0];
                end
                rffc_pkg::REG_OWN_ID: begin
                    r_own_network_id <= i_cfg_wdata[rffc_pkg::NET_ID_W-1:0];
                end
                default: begin
                    r_frame_length <= r_frame_length;
                end
            endcase
        end
    end

    // input register
    rffc_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_status   (w_status),
        .o_req      (w_req)
    );

    // frame tracking and result register
    rffc_frame_core #(
        .ID_BYTES        (ID_BYTES),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_frame_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_frame_length   (r_frame_length),
        .i_own_network_id (r_own_network_id),
        .i_req            (w_req),
        .o_status         (w_status),
        .o_res_valid      (o_m_tvalid),
        .i_res_ready      (i_m_tready),
        .o_res            (w_res)
    );

    // result packing, zero filled to whole bytes
    assign o_m_tdata = rffc_pkg::OUT_TDATA_W'(w_res);

    // an empty result register never holds back the input side
    a_ready_when_out_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready
    ) else $error("input stalled while the result register is empty");

    // a closing byte that moves on always leaves a result behind
    a_frame_end_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_status.frame_end && w_status.advance) |=> o_m_tvalid
    ) else $error("frame end did not load the result register");

    // a new result only follows a byte held in the input register
    a_result_from_byte: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_req.valid)
    ) else $error("result appeared without a received byte");

    // the core never moves a byte that is not there
    a_advance_needs_byte: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_status.advance |-> w_req.valid
    ) else $error("frame core advanced on an empty input register");

endmodule

[rtl/rffc_in_reg.sv]
// input register for received bytes, refilled while the core drains it
module rffc_in_reg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [rffc_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // [7:0] data_byte
    input  rffc_pkg::t_core_status           i_status,
    output rffc_pkg::t_in_req                o_req
);

    logic                            r_valid;
    logic [rffc_pkg::BYTE_W-1:0]     r_data;

    // free when empty or when the held byte moves on this cycle
    assign o_s_tready = !r_valid || i_status.advance;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    // byte payload
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_data <= i_s_tdata[rffc_pkg::BYTE_W-1:0];
        end
    end

    assign o_req.valid = r_valid;
    assign o_req.data  = r_data;

endmodule

[rtl/rffc_frame_core.sv]
// frame position, crc, id capture and the result register
module rffc_frame_core #(
    parameter int ID_BYTES        = rffc_pkg::ID_BYTES_DEF,
    parameter int MAX_FRAME_BYTES = rffc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [rffc_pkg::FLEN_W-1:0]      i_frame_length,
    input  logic [rffc_pkg::NET_ID_W-1:0]    i_own_network_id,
    input  rffc_pkg::t_in_req                i_req,
    output rffc_pkg::t_core_status           o_status,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output rffc_pkg::t_result                o_res
);

    localparam int POS_W   = $clog2(MAX_FRAME_BYTES);
    localparam int ID_W    = 8 * ID_BYTES;
    localparam int MIN_LEN = (ID_BYTES + 1 > 5) ? ID_BYTES + 1 : 5;
    localparam int CW      = rffc_pkg::CMP_W;

    logic [POS_W-1:0]             r_pos,  n_pos;
    logic [rffc_pkg::BYTE_W-1:0]  r_crc,  n_crc;
    logic [ID_W-1:0]              r_id,   n_id;
    logic [rffc_pkg::BYTE_W-1:0]  r_msg,  n_msg;
    logic                         r_out_valid;
    rffc_pkg::t_result            r_out,  n_out;

    logic [CW-1:0]                w_len_ext;
    logic [CW-1:0]                w_eff_len;
    logic [CW-1:0]                w_last;
    logic [CW-1:0]                w_pos_ext;
    logic                         w_is_last;
    logic                         w_advance;
    logic [rffc_pkg::BYTE_W-1:0]  w_b;

    // effective frame length, clamped to the legal window
    always_comb begin
        w_len_ext = CW'(i_frame_length);
        if (w_len_ext < CW'(MIN_LEN)) begin
            w_eff_len = CW'(MIN_LEN);
        end else begin
            w_eff_len = w_len_ext;
        end
        if (w_eff_len > CW'(MAX_FRAME_BYTES)) begin
            w_eff_len = CW'(MAX_FRAME_BYTES);
        end
        w_last = w_eff_len - CW'(1);
    end

    assign w_b       = i_req.data;
    assign w_pos_ext = CW'(r_pos);
    assign w_is_last = (w_pos_ext >= w_last);

    // a result byte waits only for room in the result register
    assign w_advance = i_req.valid && (!w_is_last || !r_out_valid || i_res_ready);

    assign o_status.advance   = w_advance;
    assign o_status.frame_end = i_req.valid && w_is_last;

    // next frame state and the verdict for a closing byte
    always_comb begin
        n_id  = r_id;
        n_msg = r_msg;
        n_crc = r_crc;
        n_pos = r_pos;
        if (w_pos_ext < CW'(ID_BYTES)) begin
            n_id = ID_W'({r_id, w_b});
        end
        if (w_pos_ext == CW'(ID_BYTES)) begin
            n_msg = w_b;
        end

        n_out.crc_good           = (r_crc == w_b);
        n_out.own_id_match       = (n_id == ID_W'(i_own_network_id));
        n_out.universal_id_match = (n_id == ~ID_W'(1));
        n_out.frame_network_id   = rffc_pkg::NET_ID_W'(n_id);
        n_out.message_byte       = n_msg;

        if (w_is_last) begin
            n_pos = '0;
            n_crc = '0;
            n_id  = '0;
            n_msg = '0;
        end else begin
            n_crc = rffc_pkg::crc8_update(r_crc, w_b);
            n_pos = r_pos + POS_W'(1);
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= '0;
            r_id  <= '0;
            r_msg <= '0;
        end else if (w_advance) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            r_id  <= n_id;
            r_msg <= n_msg;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_advance && w_is_last) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

[test/tb_top.sv]
// self-checking testbench for the fixed-length crc-8 frame checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W      = rffc_pkg::BYTE_W;
    localparam int NET_ID_W    = rffc_pkg::NET_ID_W;
    localparam int FLEN_W      = rffc_pkg::FLEN_W;
    localparam int CFG_DATA_W  = rffc_pkg::CFG_DATA_W;
    localparam int CFG_INDEX_W = rffc_pkg::CFG_INDEX_W;
    localparam int CFG_PAD_W   = CFG_DATA_W - FLEN_W;
    localparam int ID_LEN      = rffc_pkg::ID_BYTES_DEF;
    localparam int MAX_LEN     = rffc_pkg::MAX_FRAME_BYTES_DEF;
    localparam int MIN_LEN     = (ID_LEN + 1 > 5) ? ID_LEN + 1 : 5;
    localparam int TOTAL_BYTES = 1450;
    localparam int QUIET_FROM  = 1250;
    localparam int SETTLE      = 6;

    // directed script: register writes, plain bytes, and bytes that carry the running crc
    typedef enum logic [1:0] {ROW_BYTE, ROW_CRC, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_INDEX_W-1:0]  index;
        logic [CFG_DATA_W-1:0]   value;
        logic                    typed;
        rffc_pkg::t_result       verdict;
    } t_script_row;

    localparam int SCRIPT_ROWS = 26;

    // verdict fields: message, id, universal, own, crc
    t_script_row script [SCRIPT_ROWS] = '{
        // all-zero frame at reset length, wrong crc byte, id matches reset own id
        '{ROW_BYTE, '0, 32'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h01, 1'b1, '{8'h00, 32'h0000_0000, 1'b0, 1'b1, 1'b0}},
        // universal id with a good crc
        '{ROW_BYTE, '0, 32'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 32'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 32'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 32'hFE, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h80, 1'b0, '0},
        '{ROW_CRC,  '0, 32'h00, 1'b1, '{8'h80, 32'hFFFF_FFFE, 1'b1, 1'b0, 1'b1}},
        // length below range acts as shortest frame, crc byte doubles as message
        '{ROW_CFG, rffc_pkg::REG_FRAME_LENGTH, 32'h0000_0000, 1'b0, '0},
        '{ROW_CFG, rffc_pkg::REG_OWN_ID,       32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_BYTE, '0, 32'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 32'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 32'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 32'hFF, 1'b0, '0},
        '{ROW_CRC,  '0, 32'h00, 1'b0, '0},
        // length shortened in the middle of a frame, upper write bits ignored
        '{ROW_CFG, rffc_pkg::REG_FRAME_LENGTH, 32'hABCD_EF10, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h12, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h34, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h56, 1'b0, '0},
        '{ROW_CFG, rffc_pkg::REG_FRAME_LENGTH, 32'h0000_0005, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h78, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h9A, 1'b0, '0}
    };

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_s_tvalid = 1'b0;
    logic                                 o_s_tready;
    logic [rffc_pkg::IN_TDATA_W-1:0]      i_s_tdata = '0;
    logic                                 o_m_tvalid;
    logic                                 i_m_tready = 1'b1;
    logic [rffc_pkg::OUT_TDATA_W-1:0]     o_m_tdata;
    logic                                 i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]               i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]                i_cfg_wdata = '0;

    // frame tracker state and register copies
    int                      frame_pos = 0;
    logic [BYTE_W-1:0]       frame_crc = '0;
    logic [NET_ID_W-1:0]     frame_id = '0;
    logic [BYTE_W-1:0]       frame_msg = '0;
    logic [FLEN_W-1:0]       cfg_frame_len = rffc_pkg::FRAME_LENGTH_RST;
    logic [NET_ID_W-1:0]     cfg_own_id = rffc_pkg::OWN_ID_RST;

    rffc_pkg::t_result       pending_verdicts[$];
    rffc_pkg::t_result       want_verdict;
    rffc_pkg::t_result       got_verdict;
    int                      err_count = 0;
    int                      bytes_sent = 0;
    int                      src_gap_pct = 0;
    int                      sink_stall_pct = 0;
    int                      stall_left = 0;

    rx_fixed_frame_crc8_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // crc-8 poly 0x07, msb first
    function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = crc ^ b;
        repeat (8) r = (r << 1) ^ (r[7] ? rffc_pkg::CRC_POLY : 8'h00);
        return r;
    endfunction

    // index of the closing byte under the current length setting
    function automatic int last_index();
        int n;
        n = cfg_frame_len;
        if (n < MIN_LEN) n = MIN_LEN;
        if (n > MAX_LEN) n = MAX_LEN;
        return n - 1;
    endfunction

    // advance the frame tracker by one byte, returns 1 when the frame closes
    function automatic logic frame_step(input logic [BYTE_W-1:0] b,
                                        output rffc_pkg::t_result v);
        int last;
        last = last_index();
        v = '0;
        if (frame_pos < ID_LEN) frame_id = {frame_id[NET_ID_W-9:0], b};
        if (frame_pos == ID_LEN) frame_msg = b;
        if (frame_pos < last) begin
            frame_crc = crc8_next(frame_crc, b);
            frame_pos++;
            return 1'b0;
        end
        v.crc_good           = (frame_crc == b);
        v.own_id_match       = (frame_id == cfg_own_id);
        v.universal_id_match = (frame_id == 32'hFFFF_FFFE);
        v.frame_network_id   = frame_id;
        v.message_byte       = frame_msg;
        frame_pos = 0;
        frame_crc = '0;
        frame_id  = '0;
        frame_msg = '0;
        return 1'b1;
    endfunction

    // one byte request, with an optional idle burst ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                             input rffc_pkg::t_result typed_verdict);
        rffc_pkg::t_result v;
        if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(15, 0)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
        if (frame_step(b, v)) pending_verdicts.push_back(typed ? typed_verdict : v);
    endtask

    // register write once the block has drained
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        if (idx == rffc_pkg::REG_FRAME_LENGTH) cfg_frame_len = val[FLEN_W-1:0];
        else cfg_own_id = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // well-formed frame from wherever the tracker stands
    task automatic send_frame(input logic [NET_ID_W-1:0] id, input logic [BYTE_W-1:0] msg,
                              input logic good);
        logic [BYTE_W-1:0] b;
        do begin
            if (frame_pos >= last_index()) b = good ? frame_crc : BYTE_W'($urandom);
            else if (frame_pos < ID_LEN) b = id[8*(ID_LEN-1-frame_pos) +: 8];
            else if (frame_pos == ID_LEN) b = msg;
            else b = BYTE_W'($urandom);
            send_byte(b, 1'b0, '0);
        end while (frame_pos != 0);
    endtask

    function automatic logic [NET_ID_W-1:0] pick_net_id();
        case ($urandom_range(9))
            0, 1, 2: return cfg_own_id;
            3, 4:    return 32'hFFFF_FFFE;
            5, 6:    return $urandom;
            7:       return cfg_own_id ^ (32'h1 << $urandom_range(31));
            8:       return 32'hFFFF_FFFE ^ (32'h1 << $urandom_range(31));
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 10;
            default: return 30;
        endcase
    endfunction

    // receiver stalls in bursts of random length
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
            stall_left <= $urandom_range(15, 0);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            err_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_verdict = o_m_tdata[rffc_pkg::RES_W-1:0];
            if (pending_verdicts.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got %h", $time, o_m_tdata);
                err_count++;
            end else begin
                want_verdict = pending_verdicts.pop_front();
                check_field("crc_good", want_verdict.crc_good, got_verdict.crc_good);
                check_field("own_id_match", want_verdict.own_id_match,
                            got_verdict.own_id_match);
                check_field("universal_id_match", want_verdict.universal_id_match,
                            got_verdict.universal_id_match);
                check_field("frame_network_id", want_verdict.frame_network_id,
                            got_verdict.frame_network_id);
                check_field("message_byte", want_verdict.message_byte,
                            got_verdict.message_byte);
            end
        end
    end

    // stimulus
    initial begin
        int phase;
        int phase_end;
        logic [FLEN_W-1:0] len_val;
        logic [CFG_DATA_W-1:0] len_word;

        phase = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed script
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        foreach (script[i]) begin
            case (script[i].kind)
                ROW_CFG:  write_reg(script[i].index, script[i].value);
                ROW_CRC:  send_byte(frame_crc, script[i].typed, script[i].verdict);
                default:  send_byte(script[i].value[BYTE_W-1:0], script[i].typed,
                                    script[i].verdict);
            endcase
        end

        // random phases, each under its own register setting
        while (bytes_sent < TOTAL_BYTES) begin
            phase++;
            if (bytes_sent >= QUIET_FROM) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end else begin
                src_gap_pct    = pick_idle_pct();
                sink_stall_pct = pick_idle_pct();
            end
            case (phase % 6)
                0:       len_val = 5'd0;
                1:       len_val = 5'd5;
                2:       len_val = 5'd16;
                3:       len_val = 5'd31;
                4:       len_val = FLEN_W'($urandom);
                default: len_val = FLEN_W'($urandom_range(15, 6));
            endcase
            // every third write also sets the unused upper bits
            len_word = {CFG_PAD_W'($urandom), len_val};
            if (phase % 3 != 0) len_word = CFG_DATA_W'(len_val);
            write_reg(rffc_pkg::REG_FRAME_LENGTH, len_word);
            if (phase % 2 == 1) begin
                case ($urandom_range(3))
                    0:       write_reg(rffc_pkg::REG_OWN_ID, 32'h0000_0000);
                    1:       write_reg(rffc_pkg::REG_OWN_ID, 32'hFFFF_FFFF);
                    2:       write_reg(rffc_pkg::REG_OWN_ID, 32'hFFFF_FFFE);
                    default: write_reg(rffc_pkg::REG_OWN_ID, $urandom);
                endcase
            end
            phase_end = bytes_sent + 40 + $urandom_range(60);
            while (bytes_sent < phase_end && bytes_sent < TOTAL_BYTES) begin
                if ($urandom_range(9) == 0) begin
                    // stray bytes shift the frame boundary
                    repeat ($urandom_range(5, 1)) send_byte(BYTE_W'($urandom), 1'b0, '0);
                end else begin
                    send_frame(pick_net_id(), BYTE_W'($urandom), $urandom_range(4) != 0);
                end
            end
        end

        // drain
        @(negedge i_clk);
        i_s_tvalid     = 1'b0;
        sink_stall_pct = 0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
